/* hdl/tbt_pkg.sv */
// Shared types, constants and arithmetic helpers for the token bucket throttle.
`default_nettype none
package tbt_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 8;
    localparam int MAX_REL     = 16;
    localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW          = $clog2(QUEUE_DEPTH + 1);
    localparam int CW          = $clog2(MAX_REL + 1);
    localparam int BAL_W       = 41;
    localparam int SUM_W       = 36;
    localparam int RAM_W       = 32 + TAG_BITS;

    typedef enum logic [2:0] {
        ACT_THROTTLE = 3'd0,
        ACT_TRY      = 3'd1,
        ACT_ACQUIRE  = 3'd2,
        ACT_TICK     = 3'd3,
        ACT_CANCEL   = 3'd4
    } act_t;

    typedef enum logic [3:0] {
        KIND_GRANTED     = 4'd0,
        KIND_QUEUED      = 4'd1,
        KIND_REFUSED     = 4'd2,
        KIND_QUEUE_FULL  = 4'd3,
        KIND_RELEASED    = 4'd4,
        KIND_REL_CANCEL  = 4'd5,
        KIND_CANCEL_MARK = 4'd6,
        KIND_CANCEL_MISS = 4'd7,
        KIND_ACQUIRED    = 4'd8,
        KIND_TICK_IDLE   = 4'd9
    } kind_t;

    typedef enum logic [0:0] {
        CFG_LIMIT_EN = 1'd0,
        CFG_TOKENS   = 1'd1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EXEC,
        CMD_TICK_IDLE,
        CMD_TREAD,
        CMD_TREL,
        CMD_CREAD,
        CMD_CMISS,
        CMD_CHIT,
        CMD_CNEXT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic is_cancel;
        logic rel_ok;
        logic rel_more;
        logic out_free;
        logic cidx_in;
        logic cmatch;
    } status_t;

    function automatic logic signed [BAL_W-1:0] sat_deduct(
        input logic signed [BAL_W-1:0] bal,
        input logic [31:0]             amt
    );
        logic signed [BAL_W:0] diff;
        diff = {bal[BAL_W-1], bal} - $signed({(BAL_W-31)'(0), amt});
        if (diff[BAL_W] && !diff[BAL_W-1]) begin
            return {1'b1, (BAL_W-1)'(0)};
        end
        return diff[BAL_W-1:0];
    endfunction

    function automatic logic signed [BAL_W-1:0] tick_add(
        input logic signed [BAL_W-1:0] bal,
        input logic [31:0]             tpp
    );
        logic signed [BAL_W:0] sum;
        logic signed [BAL_W:0] cap;
        cap = $signed({(BAL_W-31)'(0), tpp});
        sum = {bal[BAL_W-1], bal} + cap;
        if (sum > cap) begin
            return cap[BAL_W-1:0];
        end
        return sum[BAL_W-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_add(
        input logic [AW-1:0] head,
        input logic [FW-1:0] off
    );
        logic [FW:0] s;
        s = (FW+1)'(head) + (FW+1)'(off);
        if (s >= (FW+1)'(QUEUE_DEPTH)) begin
            s = s - (FW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/tbt_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* hdl/tbt_datapath.sv */
// Datapath: balance, wait queue, config registers and result register.
`default_nettype none
module tbt_datapath
    import tbt_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cmd_t                    cmd,
    output status_t                      st,
    input  wire logic                    cfg_wr_en,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [31:0]             cfg_wdata,
    input  wire logic [2:0]              s_action,
    input  wire logic [31:0]             s_amount,
    input  wire logic [7:0]              s_request_tag,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [3:0]                   m_result_kind,
    output logic [7:0]                   m_result_tag,
    output logic [31:0]                  m_result_amount,
    output logic signed [BAL_W-1:0]      m_balance_now,
    output logic                         m_overdraft,
    output logic [SUM_W-1:0]             m_queued_total,
    output logic                         m_last
);

    logic                     lim_reg, lim_next;
    logic [31:0]              tpp_reg, tpp_next;
    logic signed [BAL_W-1:0]  bal_reg, bal_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [FW-1:0]            fill_reg, fill_next;
    logic [QUEUE_DEPTH-1:0]   canc_reg, canc_next;
    logic [CW-1:0]            rcnt_reg, rcnt_next;
    logic [FW-1:0]            cidx_reg, cidx_next;
    logic [AW-1:0]            cslot_reg, cslot_next;
    logic [2:0]               act_reg, act_next;
    logic [31:0]              amt_reg, amt_next;
    logic [TAG_BITS-1:0]      tag_reg, tag_next;

    logic                     mv_reg, mv_next;
    kind_t                    kind_reg, kind_next;
    logic [7:0]               otag_reg, otag_next;
    logic [31:0]              oamt_reg, oamt_next;
    logic signed [BAL_W-1:0]  obal_reg, obal_next;
    logic [SUM_W-1:0]         osum_reg, osum_next;
    logic                     olast_reg, olast_next;

    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [RAM_W-1:0]         ram_rdata;
    logic [31:0]              rd_amt;
    logic [TAG_BITS-1:0]      rd_tag;
    logic                     bal_pos, rel_pos;
    logic signed [BAL_W-1:0]  rel_bal;
    logic                     rd_canc;
    logic [AW-1:0]            cslot_calc;
    logic                     emit;
    kind_t                    e_kind;
    logic [TAG_BITS-1:0]      e_tag;
    logic [31:0]              e_amt;
    logic                     e_last;

    tbt_ram #(
        .WIDTH(RAM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_wait_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({amt_reg, tag_reg}),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_amt     = ram_rdata[RAM_W-1:TAG_BITS];
    assign rd_tag     = ram_rdata[TAG_BITS-1:0];
    assign bal_pos    = !bal_reg[BAL_W-1] && (bal_reg != '0);
    assign rd_canc    = canc_reg[cslot_reg];
    assign cslot_calc = slot_add(head_reg, cidx_reg);
    assign rel_bal    = (!canc_reg[head_reg] && lim_reg) ? sat_deduct(bal_reg, rd_amt) : bal_reg;
    assign rel_pos    = !rel_bal[BAL_W-1] && (rel_bal != '0);

    always_comb begin
        st.is_tick   = (act_reg == ACT_TICK);
        st.is_cancel = (act_reg == ACT_CANCEL);
        st.rel_ok    = (fill_reg != '0) && (!lim_reg || bal_pos);
        st.rel_more  = (fill_reg > FW'(1)) && (rcnt_reg + CW'(1) < CW'(MAX_REL))
                       && (!lim_reg || rel_pos);
        st.out_free  = !mv_reg || m_ready;
        st.cidx_in   = (cidx_reg < fill_reg);
        st.cmatch    = !rd_canc && (rd_tag == tag_reg);
    end

    always_comb begin
        lim_next   = lim_reg;
        tpp_next   = tpp_reg;
        bal_next   = bal_reg;
        sum_next   = sum_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        canc_next  = canc_reg;
        rcnt_next  = rcnt_reg;
        cidx_next  = cidx_reg;
        cslot_next = cslot_reg;
        act_next   = act_reg;
        amt_next   = amt_reg;
        tag_next   = tag_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = slot_add(head_reg, fill_reg);
        ram_raddr  = head_reg;
        emit       = 1'b0;
        e_kind     = KIND_GRANTED;
        e_tag      = tag_reg;
        e_amt      = amt_reg;
        e_last     = 1'b1;

        unique case (cmd.op)
            CMD_LOAD: begin
                act_next = s_action;
                amt_next = s_amount;
                tag_next = s_request_tag[TAG_BITS-1:0];
            end
            CMD_EXEC: begin
                rcnt_next = '0;
                cidx_next = '0;
                unique case (act_reg)
                    ACT_THROTTLE: begin
                        emit = 1'b1;
                        if (amt_reg == '0 || !lim_reg) begin
                            e_kind = KIND_GRANTED;
                        end else if (bal_pos) begin
                            bal_next = sat_deduct(bal_reg, amt_reg);
                            e_kind   = KIND_GRANTED;
                        end else if (fill_reg >= FW'(QUEUE_DEPTH)) begin
                            e_kind = KIND_QUEUE_FULL;
                        end else begin
                            ram_we                                  = 1'b1;
                            canc_next[slot_add(head_reg, fill_reg)] = 1'b0;
                            fill_next = fill_reg + FW'(1);
                            sum_next  = sum_reg + SUM_W'(amt_reg);
                            e_kind    = KIND_QUEUED;
                        end
                    end
                    ACT_TRY: begin
                        emit = 1'b1;
                        if (amt_reg == '0 || !lim_reg) begin
                            e_kind = KIND_GRANTED;
                        end else if (!bal_pos) begin
                            e_kind = KIND_REFUSED;
                        end else begin
                            bal_next = sat_deduct(bal_reg, amt_reg);
                            e_kind   = KIND_GRANTED;
                        end
                    end
                    ACT_ACQUIRE: begin
                        emit   = 1'b1;
                        e_kind = KIND_ACQUIRED;
                        if (amt_reg != '0 && lim_reg) begin
                            bal_next = sat_deduct(bal_reg, amt_reg);
                        end
                    end
                    ACT_TICK: begin
                        bal_next = tick_add(bal_reg, tpp_reg);
                    end
                    ACT_CANCEL: begin
                    end
                    default: begin
                        emit   = 1'b1;
                        e_kind = KIND_REFUSED;
                    end
                endcase
            end
            CMD_TICK_IDLE: begin
                emit   = 1'b1;
                e_kind = KIND_TICK_IDLE;
                e_tag  = '0;
                e_amt  = '0;
            end
            CMD_TREAD: begin
                ram_re    = 1'b1;
                ram_raddr = head_reg;
            end
            CMD_TREL: begin
                emit      = 1'b1;
                e_kind    = canc_reg[head_reg] ? KIND_REL_CANCEL : KIND_RELEASED;
                e_tag     = rd_tag;
                e_amt     = rd_amt;
                e_last    = !st.rel_more;
                bal_next  = rel_bal;
                sum_next  = sum_reg - SUM_W'(rd_amt);
                head_next = slot_add(head_reg, FW'(1));
                fill_next = fill_reg - FW'(1);
                rcnt_next = rcnt_reg + CW'(1);
            end
            CMD_CREAD: begin
                ram_re     = 1'b1;
                ram_raddr  = cslot_calc;
                cslot_next = cslot_calc;
            end
            CMD_CMISS: begin
                emit   = 1'b1;
                e_kind = KIND_CANCEL_MISS;
                e_amt  = '0;
            end
            CMD_CHIT: begin
                emit                 = 1'b1;
                e_kind               = KIND_CANCEL_MARK;
                e_amt                = rd_amt;
                canc_next[cslot_reg] = 1'b1;
            end
            CMD_CNEXT: begin
                cidx_next = cidx_reg + FW'(1);
            end
            default: begin
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LIMIT_EN: lim_next = cfg_wdata[0];
                CFG_TOKENS: begin
                    tpp_next = cfg_wdata;
                    bal_next = $signed({(BAL_W-32)'(0), cfg_wdata});
                end
                default: begin
                end
            endcase
        end

        mv_next    = emit ? 1'b1 : (mv_reg && !m_ready);
        kind_next  = emit ? e_kind : kind_reg;
        otag_next  = emit ? 8'(e_tag) : otag_reg;
        oamt_next  = emit ? e_amt : oamt_reg;
        obal_next  = emit ? bal_next : obal_reg;
        osum_next  = emit ? sum_next : osum_reg;
        olast_next = emit ? e_last : olast_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg  <= 1'b1;
            tpp_reg  <= '0;
            bal_reg  <= '0;
            sum_reg  <= '0;
            head_reg <= '0;
            fill_reg <= '0;
            canc_reg <= '0;
            mv_reg   <= 1'b0;
        end else begin
            lim_reg  <= lim_next;
            tpp_reg  <= tpp_next;
            bal_reg  <= bal_next;
            sum_reg  <= sum_next;
            head_reg <= head_next;
            fill_reg <= fill_next;
            canc_reg <= canc_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        rcnt_reg  <= rcnt_next;
        cidx_reg  <= cidx_next;
        cslot_reg <= cslot_next;
        act_reg   <= act_next;
        amt_reg   <= amt_next;
        tag_reg   <= tag_next;
        kind_reg  <= kind_next;
        otag_reg  <= otag_next;
        oamt_reg  <= oamt_next;
        obal_reg  <= obal_next;
        osum_reg  <= osum_next;
        olast_reg <= olast_next;
    end

    assign m_valid         = mv_reg;
    assign m_result_kind   = kind_reg;
    assign m_result_tag    = otag_reg;
    assign m_result_amount = oamt_reg;
    assign m_balance_now   = obal_reg;
    assign m_overdraft     = obal_reg[BAL_W-1];
    assign m_queued_total  = osum_reg;
    assign m_last          = olast_reg;

endmodule
`default_nettype wire

/* hdl/tbt_ctrl.sv */
// Controller state machine sequencing requests, tick releases and cancel scans.
`default_nettype none
module tbt_ctrl
    import tbt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_TREAD = 6'b000100,
        S_TREL  = 6'b001000,
        S_CREAD = 6'b010000,
        S_CCHK  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE) && st.out_free;

    always_comb begin
        state_next = state_reg;
        cmd.op     = CMD_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.op = CMD_EXEC;
                if (st.is_tick) begin
                    state_next = S_TREAD;
                end else if (st.is_cancel) begin
                    state_next = S_CREAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_TREAD: begin
                if (st.rel_ok) begin
                    cmd.op     = CMD_TREAD;
                    state_next = S_TREL;
                end else begin
                    cmd.op     = CMD_TICK_IDLE;
                    state_next = S_IDLE;
                end
            end
            S_TREL: begin
                if (st.out_free) begin
                    cmd.op     = CMD_TREL;
                    state_next = st.rel_more ? S_TREAD : S_IDLE;
                end
            end
            S_CREAD: begin
                if (st.cidx_in) begin
                    cmd.op     = CMD_CREAD;
                    state_next = S_CCHK;
                end else begin
                    cmd.op     = CMD_CMISS;
                    state_next = S_IDLE;
                end
            end
            S_CCHK: begin
                if (st.cmatch) begin
                    cmd.op     = CMD_CHIT;
                    state_next = S_IDLE;
                end else begin
                    cmd.op     = CMD_CNEXT;
                    state_next = S_CREAD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/token_bucket_throttle_with_wait_queue.sv */
// Top level of the token bucket throttle with wait queue.
// A throttle, try-acquire, acquire or unknown action executes in the cycle after
// acceptance, and its result is registered into the output register at the end of
// that cycle. A new transaction is accepted once the controller is idle and the
// output register is empty or being taken in the same cycle, so a new request is not
// taken while the previous one is still executing. A tick that releases nothing
// ends with a tick-idle result; otherwise it releases up to 16 queue entries, one
// wait-RAM read each; a release stalls while the output register is held. A cancel
// reads the queue entries in turn and emits a miss result when none matches.
`default_nettype none
module token_bucket_throttle_with_wait_queue
    import tbt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_action,
    input  wire logic [31:0]        s_amount,
    input  wire logic [7:0]         s_request_tag,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_result_kind,
    output logic [7:0]              m_result_tag,
    output logic [31:0]             m_result_amount,
    output logic signed [BAL_W-1:0] m_balance_now,
    output logic                    m_overdraft,
    output logic [SUM_W-1:0]        m_queued_total,
    output logic                    m_last
);

    cmd_t    cmd;
    status_t st;

    tbt_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .st     (st),
        .cmd    (cmd)
    );

    tbt_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_action       (s_action),
        .s_amount       (s_amount),
        .s_request_tag  (s_request_tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_result_tag   (m_result_tag),
        .m_result_amount(m_result_amount),
        .m_balance_now  (m_balance_now),
        .m_overdraft    (m_overdraft),
        .m_queued_total (m_queued_total),
        .m_last         (m_last)
    );

endmodule
`default_nettype wire
